[design/sfp_pkg.sv]
// Shared constants and types for the sync frame parser.
package sfp_pkg;

    // Sync pattern and frame layout
    localparam logic [7:0]  SYNC_FIRST     = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND    = 8'h55;
    localparam int          FRAME_BYTES    = 20;
    localparam int          POS_W          = 5;
    localparam logic [POS_W-1:0] POS_BODY_START = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SEC_START  = POS_W'(10);
    localparam logic [POS_W-1:0] POS_SUB_START  = POS_W'(14);
    localparam logic [POS_W-1:0] POS_CHECK      = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);
    localparam logic [15:0] GOOD_TOTAL     = 16'hFFFF;

    // Word widths on the stream ports
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 128;

    // Framer phase, one-hot
    typedef enum logic [2:0] {
        PH_HUNT  = 3'b001,
        PH_SYNC1 = 3'b010,
        PH_BODY  = 3'b100
    } phase_t;

    // Fields of one decoded frame
    typedef struct packed {
        logic [31:0] gps_subseconds;
        logic [31:0] gps_seconds;
        logic [63:0] image_id;
    } sfp_result_t;

    // Framer status seen by the top level
    typedef struct packed {
        logic             hunting;
        logic             in_body;
        logic [POS_W-1:0] pos;
    } sfp_status_t;

endpackage

[design/sync_frame_parser_with_checksum.sv]
// Top level of the sync frame parser with 16-bit additive checksum.
// Accepts one received byte per word and can take a word every clock cycle. It hunts for
// the sync pair 0xAA 0x55, collects the rest of a 20-byte frame and checks that bytes 2..17
// plus the big-endian checksum in bytes 18..19 total 0xFFFF. A good frame gives one result
// word, which passes through the input register and then the result register; a bad frame
// is dropped whole, and a sync pattern inside a frame is plain data. Throughput is one byte
// per cycle; the input stalls only while a result word waits on m_tready. No clearing pass
// after reset.
module sync_frame_parser_with_checksum
    import sfp_pkg::*;
#(
    parameter int IN_W  = IN_DATA_W,
    parameter int OUT_W = OUT_DATA_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [63:0] image_id, [95:64] gps_seconds,
                                        // [127:96] gps_subseconds
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        can_load;
    logic        proc_fire;
    logic        res_valid;
    sfp_result_t res;
    sfp_status_t status;
    logic [OUT_DATA_W-1:0] out_word;

    // Consume the held word whenever the result side can take a result
    assign proc_fire = in_valid_reg && can_load;
    assign s_tready  = !in_valid_reg || can_load;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata[7:0];
        end
    end

    sfp_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (proc_fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    sfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (out_word)
    );

    assign m_tdata = OUT_W'(out_word);

`ifndef SYNTH
    // A result leaves the framer hunting again
    a_hunt_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> status.hunting)
        else $error("framer not hunting after a result");

    // Body position stays inside the frame
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        status.in_body |-> (status.pos >= POS_BODY_START && status.pos <= POS_LAST))
        else $error("body position out of frame");

    // A result never overwrites a word still waiting on the master side
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_tvalid || m_tready))
        else $error("result dropped over a stalled word");

    // Reset empties both registers
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_valid_reg))
        else $error("registers not empty after reset");
`endif

endmodule

[design/sfp_framer.sv]
// Sync hunt, frame collection and checksum check, one byte per cycle while byte_en is high.
module sfp_framer
    import sfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_en,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output sfp_result_t res,
    output sfp_status_t status
);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic [63:0]      id_reg, id_next;
    logic [31:0]      sec_reg, sec_next;
    logic [31:0]      sub_reg, sub_next;
    logic [15:0]      check_reg, check_next;
    logic [15:0]      total;

    // Advance the frame state on each byte
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        id_next    = id_reg;
        sec_next   = sec_reg;
        sub_next   = sub_reg;
        check_next = check_reg;
        res_valid  = 1'b0;
        total      = 16'h0000;
        if (byte_en) begin
            unique case (phase_reg)
                PH_SYNC1: begin
                    if (rx_byte == SYNC_SECOND) begin
                        phase_next = PH_BODY;
                        pos_next   = POS_BODY_START;
                        sum_next   = 16'h0000;
                        id_next    = 64'h0;
                        sec_next   = 32'h0;
                        sub_next   = 32'h0;
                        check_next = 16'h0000;
                    end else if (rx_byte != SYNC_FIRST) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (pos_reg < POS_BODY_START || pos_reg > POS_LAST) begin
                        // drop a frame whose position went astray
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                        sum_next   = 16'h0000;
                    end else begin
                        if (pos_reg < POS_CHECK) begin
                            sum_next = sum_reg + {8'h00, rx_byte};
                            if (pos_reg < POS_SEC_START) begin
                                id_next = {id_reg[55:0], rx_byte};
                            end else if (pos_reg < POS_SUB_START) begin
                                sec_next = {sec_reg[23:0], rx_byte};
                            end else begin
                                sub_next = {sub_reg[23:0], rx_byte};
                            end
                        end else begin
                            check_next = {check_reg[7:0], rx_byte};
                        end
                        if (pos_reg == POS_LAST) begin
                            // check the sum, emit on good, drop on bad
                            total      = sum_reg + check_next;
                            res_valid  = (total == GOOD_TOTAL);
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                            sum_next   = 16'h0000;
                        end else begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end
                end
                default: begin
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            sum_reg   <= 16'h0000;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    // Hold field shift registers
    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        sec_reg   <= sec_next;
        sub_reg   <= sub_next;
        check_reg <= check_next;
    end

    assign res.image_id       = id_reg;
    assign res.gps_seconds    = sec_reg;
    assign res.gps_subseconds = sub_reg;

    assign status.hunting = (phase_reg == PH_HUNT);
    assign status.in_body = (phase_reg == PH_BODY);
    assign status.pos     = pos_reg;

endmodule

[design/sfp_out_stage.sv]
// Result register on the master side of the stream.
module sfp_out_stage
    import sfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  sfp_result_t           res,
    output logic                  can_load,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;

    // Take a new result when empty or when the held one leaves
    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
